### design/twct_pkg.sv
// Shared types and constants of the time-window coincidence trigger.
`default_nettype none
package twct_pkg;

  localparam int TIME_W = 63;
  localparam int UNIT_W = 16;
  localparam int EVN_W  = 32;
  localparam int SAT_W  = 6;
  localparam int DROP_W = 16;
  localparam int WIN_W  = 31;
  localparam int THR_W  = 6;

  localparam int DEFAULT_DEPTH = 32;

  localparam logic [TIME_W-1:0] TIME_LIMIT = 63'd1740000000000000000;
  localparam logic [WIN_W-1:0]  WINDOW_RESET = 31'd1000;
  localparam logic [THR_W-1:0]  THRESH_RESET = 6'd4;

  // configuration register indexes
  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_THRESH = 1'b1
  } reg_idx_e;

  // command to the unit-id set
  typedef struct packed {
    logic              clr;
    logic              inc;
    logic              dec;
    logic [UNIT_W-1:0] unit;
  } unit_op_t;

endpackage
`default_nettype wire

### design/twct_hit_if.sv
// Input channel: one detector hit or an end-of-run word.
`default_nettype none
interface twct_hit_if;
  logic                          valid;
  logic                          ready;
  logic [twct_pkg::TIME_W-1:0]   hit_time;
  logic [twct_pkg::UNIT_W-1:0]   unit_id;
  logic                          end_of_run;

  modport source (output valid, hit_time, unit_id, end_of_run, input ready);
  modport sink   (input valid, hit_time, unit_id, end_of_run, output ready);
endinterface
`default_nettype wire

### design/twct_evt_if.sv
// Output channel: one member hit of a triggered event per word.
`default_nettype none
interface twct_evt_if;
  logic                          valid;
  logic                          ready;
  logic [twct_pkg::EVN_W-1:0]    event_number;
  logic [twct_pkg::TIME_W-1:0]   member_time;
  logic [twct_pkg::UNIT_W-1:0]   member_unit;
  logic [twct_pkg::SAT_W-1:0]    distinct_units;
  logic [twct_pkg::SAT_W-1:0]    hit_count;
  logic                          last_member;
  logic [twct_pkg::DROP_W-1:0]   dropped_hits;

  modport source (output valid, event_number, member_time, member_unit, distinct_units,
                  hit_count, last_member, dropped_hits, input ready);
  modport sink   (input valid, event_number, member_time, member_unit, distinct_units,
                  hit_count, last_member, dropped_hits, output ready);
endinterface
`default_nettype wire

### design/twct_unit_set.sv
// Set of unit ids among the pending hits, with a use count per id.
`default_nettype none
module twct_unit_set #(
  parameter int WINDOW_DEPTH = twct_pkg::DEFAULT_DEPTH,
  parameter int CNT_W        = $clog2(WINDOW_DEPTH + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  twct_pkg::unit_op_t   op_i,
  output logic [CNT_W-1:0]     distinct_o
);
  import twct_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);

  logic [WINDOW_DEPTH-1:0] vld_q;
  logic [UNIT_W-1:0]       id_q  [WINDOW_DEPTH];
  logic [CNT_W-1:0]        cnt_q [WINDOW_DEPTH];
  logic [CNT_W-1:0]        distinct_q;

  logic [WINDOW_DEPTH-1:0] match;
  logic [IDX_W-1:0]        match_idx;
  logic [IDX_W-1:0]        free_idx;
  logic                    any_match;

  // parallel id compare and first free slot
  always_comb begin
    match     = '0;
    match_idx = '0;
    free_idx  = '0;
    for (int i = WINDOW_DEPTH - 1; i >= 0; i--) begin
      match[i] = vld_q[i] && (id_q[i] == op_i.unit);
      if (match[i]) match_idx = IDX_W'(i);
      if (!vld_q[i]) free_idx = IDX_W'(i);
    end
    any_match = |match;
  end

  // valid bits and distinct count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      distinct_q <= '0;
    end else if (op_i.clr) begin
      vld_q      <= '0;
      distinct_q <= '0;
    end else if (op_i.inc && !any_match) begin
      vld_q[free_idx] <= 1'b1;
      distinct_q      <= distinct_q + 1'b1;
    end else if (op_i.dec && any_match && cnt_q[match_idx] == CNT_W'(1)) begin
      vld_q[match_idx] <= 1'b0;
      distinct_q       <= distinct_q - 1'b1;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    if (op_i.inc) begin
      if (any_match) begin
        cnt_q[match_idx] <= cnt_q[match_idx] + 1'b1;
      end else begin
        id_q[free_idx]  <= op_i.unit;
        cnt_q[free_idx] <= CNT_W'(1);
      end
    end else if (op_i.dec && any_match) begin
      cnt_q[match_idx] <= cnt_q[match_idx] - 1'b1;
    end
  end

  assign distinct_o = distinct_q;

endmodule
`default_nettype wire

### design/time_window_coincidence_trigger.sv
// Top level of the time-window coincidence trigger.
// Usage:
//   hit_i carries one word per detector hit (hit_time, unit_id) or an end-of-run
//   word (end_of_run = 1). evt_o gives one word per member hit of a triggered
//   event, oldest first, last_member set on the final one.
//   The APB port writes window_ns at 0x0 and unit_threshold at 0x4; write them
//   only while the block is idle.
// Operation:
//   Pending hits live in a one-port-read, one-port-write RAM used as a ring.
//   Each hit is filtered, then (if hits are pending) the oldest is read from RAM
//   and compared, then the hit is inserted; each oldest hit dropped while testing
//   the window repeats the RAM read and compare. Each member word of an event is
//   read from RAM, then loaded once the receiver has taken the last word, so a
//   receiver holding ready low stalls the loop over the ring through the read port.
//   The output register holds the last word, so a new hit is accepted while it
//   waits. While an event is read out the input is held off.
// Reset:
//   Empties the ring, clears the unit set, event and drop counters, and restores
//   window_ns = 1000 and unit_threshold = 4. No clearing pass is needed.
`default_nettype none
module time_window_coincidence_trigger #(
  parameter int WINDOW_DEPTH = twct_pkg::DEFAULT_DEPTH
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  twct_hit_if.sink     hit_i,
  twct_evt_if.source   evt_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [2:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import twct_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_FILT, S_RD, S_CHK, S_ERD, S_ELD, S_INS
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [UNIT_W-1:0] unit;
  } entry_t;

  // configuration registers
  logic [WIN_W-1:0] window_q;
  logic [THR_W-1:0] thresh_q;
  reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      thresh_q <= THRESH_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_WINDOW: window_q <= pwdata[WIN_W-1:0];
        REG_THRESH: thresh_q <= pwdata[THR_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW: prdata = 32'(window_q);
      REG_THRESH: prdata = 32'(thresh_q);
      default:    prdata = '0;
    endcase
  end

  // pending hit ring
  entry_t mem_q [WINDOW_DEPTH];
  entry_t mem_rdata_q;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  entry_t           mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
  end

  state_e            state_q;
  logic [IDX_W-1:0]  head_q, eptr_q;
  logic [CNT_W-1:0]  count_q, k_q, ev_n_q;
  logic [SAT_W-1:0]  ev_dist_q;
  logic [TIME_W-1:0] t_q, prev_q;
  logic [UNIT_W-1:0] u_q;
  logic              eor_q, have_prev_q;
  logic [EVN_W-1:0]  evn_q;
  logic [DROP_W-1:0] drop_q;

  logic              out_vld_q, out_last_q;
  logic [TIME_W-1:0] out_time_q;
  logic [UNIT_W-1:0] out_unit_q;
  logic [EVN_W-1:0]  out_evn_q;
  logic [SAT_W-1:0]  out_dist_q, out_cnt_q;
  logic [DROP_W-1:0] out_drop_q;

  unit_op_t          uop;
  logic [CNT_W-1:0]  distinct;

  twct_unit_set #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .CNT_W        (CNT_W)
  ) u_unit_set (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (uop),
    .distinct_o (distinct)
  );

  // helpers
  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SAT_W-1:0] sat6(input logic [CNT_W-1:0] v);
    logic [7:0] ext;
    ext  = 8'(v);
    sat6 = (ext > 8'd63) ? 6'd63 : ext[SAT_W-1:0];
  endfunction

  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail;
  logic              meets_thr;
  logic [TIME_W-1:0] diff;
  logic              window_closed;

  assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
  assign tail      = (tail_sum >= SUM_W'(WINDOW_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(tail_sum);
  assign meets_thr = (8'(distinct) >= 8'(thresh_q));
  assign diff      = t_q - mem_rdata_q.tm;
  assign window_closed = (t_q > mem_rdata_q.tm) && (diff > TIME_W'(window_q));

  // RAM and unit-set commands
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = head_q;
    mem_we    = 1'b0;
    mem_waddr = tail;
    mem_wdata = '{tm: t_q, unit: u_q};
    uop       = '{clr: 1'b0, inc: 1'b0, dec: 1'b0, unit: u_q};
    case (state_q)
      S_RD: mem_re = 1'b1;
      S_CHK: begin
        if (window_closed && !meets_thr) begin
          uop.dec  = 1'b1;
          uop.unit = mem_rdata_q.unit;
        end
      end
      S_ERD: begin
        mem_re    = !out_vld_q;
        mem_raddr = eptr_q;
      end
      S_ELD: uop.clr = (k_q == ev_n_q - 1'b1);
      S_FILT: uop.clr = eor_q && !(count_q != '0 && meets_thr);
      S_INS: begin
        if (count_q < CNT_W'(WINDOW_DEPTH)) begin
          mem_we  = 1'b1;
          uop.inc = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      have_prev_q <= 1'b0;
      prev_q      <= '0;
      evn_q       <= '0;
      drop_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (out_vld_q && evt_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (hit_i.valid) state_q <= S_FILT;
        end
        S_FILT: begin
          if (eor_q) begin
            if (count_q != '0 && meets_thr) begin
              evn_q <= evn_q + 1'b1;
              state_q <= S_ERD;
            end else begin
              count_q <= '0;
              head_q  <= '0;
              state_q <= S_IDLE;
            end
          end else if (t_q > TIME_LIMIT || (have_prev_q && t_q == prev_q)) begin
            state_q <= S_IDLE;
          end else begin
            prev_q      <= t_q;
            have_prev_q <= 1'b1;
            state_q     <= (count_q != '0) ? S_RD : S_INS;
          end
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          if (!window_closed) begin
            state_q <= S_INS;
          end else if (meets_thr) begin
            evn_q   <= evn_q + 1'b1;
            state_q <= S_ERD;
          end else begin
            head_q  <= ptr_inc(head_q);
            count_q <= count_q - 1'b1;
            state_q <= (count_q == CNT_W'(1)) ? S_INS : S_RD;
          end
        end
        S_ERD: begin
          if (!out_vld_q) state_q <= S_ELD;
        end
        S_ELD: begin
          out_vld_q <= 1'b1;
          if (k_q == ev_n_q - 1'b1) begin
            count_q <= '0;
            head_q  <= '0;
            state_q <= eor_q ? S_IDLE : S_INS;
          end else begin
            state_q <= S_ERD;
          end
        end
        S_INS: begin
          if (count_q < CNT_W'(WINDOW_DEPTH)) begin
            count_q <= count_q + 1'b1;
          end else if (drop_q != '1) begin
            drop_q <= drop_q + 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && hit_i.valid) begin
      t_q   <= hit_i.hit_time;
      u_q   <= hit_i.unit_id;
      eor_q <= hit_i.end_of_run;
    end
    if ((state_q == S_FILT && eor_q) || state_q == S_CHK) begin
      ev_n_q    <= count_q;
      ev_dist_q <= sat6(distinct);
      eptr_q    <= head_q;
      k_q       <= '0;
    end
    if (state_q == S_ELD) begin
      out_time_q <= mem_rdata_q.tm;
      out_unit_q <= mem_rdata_q.unit;
      out_last_q <= (k_q == ev_n_q - 1'b1);
      out_evn_q  <= evn_q;
      out_dist_q <= ev_dist_q;
      out_cnt_q  <= sat6(ev_n_q);
      out_drop_q <= drop_q;
      eptr_q     <= ptr_inc(eptr_q);
      k_q        <= k_q + 1'b1;
    end
  end

  assign hit_i.ready          = (state_q == S_IDLE);
  assign evt_o.valid          = out_vld_q;
  assign evt_o.event_number   = out_evn_q;
  assign evt_o.member_time    = out_time_q;
  assign evt_o.member_unit    = out_unit_q;
  assign evt_o.distinct_units = out_dist_q;
  assign evt_o.hit_count      = out_cnt_q;
  assign evt_o.last_member    = out_last_q;
  assign evt_o.dropped_hits   = out_drop_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW_DEPTH))
    else $error("pending count exceeds depth");

  a_distinct_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (distinct <= count_q))
    else $error("distinct units exceed pending hits");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ELD) |-> !out_vld_q)
    else $error("output register overwritten");

  a_evn_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ELD && out_last_q == 1'b0 && k_q != '0) |-> $stable(evn_q))
    else $error("event number changed inside an event");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !evt_o.ready) |=>
      (out_vld_q && $stable(out_evn_q) && $stable(out_time_q) &&
       $stable(out_cnt_q) && $stable(out_drop_q)))
    else $error("waiting output word changed");

endmodule
`default_nettype wire

### tb/twct_scoreboard.sv
// Scoreboard for the coincidence trigger: predicts event words and checks them.
package twct_sb_pkg;

  typedef struct packed {
    logic [31:0] evn;
    logic [62:0] mtime;
    logic [15:0] munit;
    logic [5:0]  distinct;
    logic [5:0]  count;
    logic        last;
    logic [15:0] drops;
  } event_word_t;

class twct_scoreboard;
  localparam int DEPTH = twct_pkg::DEFAULT_DEPTH;
  localparam logic [62:0] TLIM = 63'd1740000000000000000;

  logic [62:0] ring_time[$];
  logic [15:0] ring_unit[$];
  logic [62:0] prev_time;
  bit          have_prev;
  logic [31:0] event_ctr;
  logic [15:0] drop_ctr;
  logic [30:0] window_ns;
  logic [5:0]  threshold;
  event_word_t expected_words[$];
  int          errors;

  function new();
    ring_time = {};
    ring_unit = {};
    prev_time = '0;
    have_prev = 0;
    event_ctr = '0;
    drop_ctr = '0;
    window_ns = 31'd1000;
    threshold = 6'd4;
    errors = 0;
  endfunction

  function int distinct_units();
    int n;
    bit seen;
    n = 0;
    foreach (ring_unit[a]) begin
      seen = 0;
      for (int b = 0; b < a; b++) if (ring_unit[b] == ring_unit[a]) seen = 1;
      if (!seen) n++;
    end
    return n;
  endfunction

  // emit the pending group if it has enough distinct units
  function bit try_fire();
    int d;
    int n;
    event_word_t w;
    d = distinct_units();
    n = ring_time.size();
    if (n == 0 || d < threshold) return 0;
    event_ctr++;
    for (int k = 0; k < n; k++) begin
      w.evn = event_ctr;
      w.mtime = ring_time[k];
      w.munit = ring_unit[k];
      w.distinct = d[5:0];
      w.count = n[5:0];
      w.last = (k == n - 1);
      w.drops = drop_ctr;
      expected_words = {expected_words, w};
    end
    ring_time = {};
    ring_unit = {};
    return 1;
  endfunction

  function void note_hit(logic [62:0] t, logic [15:0] u, logic eor);
    if (eor) begin
      void'(try_fire());
      ring_time = {};
      ring_unit = {};
      return;
    end
    if (t > TLIM) return;
    if (have_prev && t == prev_time) return;
    prev_time = t;
    have_prev = 1;
    while (ring_time.size() > 0 && t > ring_time[0] &&
           (t - ring_time[0]) > {32'd0, window_ns}) begin
      if (try_fire()) break;
      void'(ring_time.pop_front());
      void'(ring_unit.pop_front());
    end
    if (ring_time.size() < DEPTH) begin
      ring_time = {ring_time, t};
      ring_unit = {ring_unit, u};
    end else if (drop_ctr != 16'hffff) begin
      drop_ctr++;
    end
  endfunction

  function void check_word(event_word_t got);
    event_word_t exp_w;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word %p", $realtime, got);
      errors++;
      return;
    end
    exp_w = expected_words.pop_front();
    if (exp_w != got) begin
      $display("%0t: mismatch expected %p actual %p", $realtime, exp_w, got);
      errors++;
    end
  endfunction
endclass

endpackage

### tb/time_window_coincidence_trigger_test.sv
// Testbench top: drives hits, config writes and back pressure, checks event words.
module time_window_coincidence_trigger_test;
  timeunit 1ns;
  timeprecision 1ps;
  import twct_sb_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [62:0] clock_ns;

  twct_hit_if hit_ch();
  twct_evt_if evt_ch();
  twct_scoreboard trig_sb;

  time_window_coincidence_trigger dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .hit_i(hit_ch.sink), .evt_o(evt_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    hit_ch.valid = 0;
    hit_ch.hit_time = '0;
    hit_ch.unit_id = '0;
    hit_ch.end_of_run = 0;
    evt_ch.ready = 0;
  end

  // receiver: random stalls per word, checks each accepted word
  initial begin : sink_side
    int gap;
    event_word_t w;
    wait (rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        evt_ch.ready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      evt_ch.ready <= 1;
      do @(posedge clk_i); while (!evt_ch.valid);
      w = '{evt_ch.event_number, evt_ch.member_time, evt_ch.member_unit,
            evt_ch.distinct_units, evt_ch.hit_count, evt_ch.last_member,
            evt_ch.dropped_hits};
      trig_sb.check_word(w);
    end
  end

  task automatic send_word(logic [62:0] t, logic [15:0] u, logic eor, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      hit_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    hit_ch.valid <= 1;
    hit_ch.hit_time <= t;
    hit_ch.unit_id <= u;
    hit_ch.end_of_run <= eor;
    do @(posedge clk_i); while (!hit_ch.ready);
    trig_sb.note_hit(t, u, eor);
  endtask

  task automatic send_hit(logic [62:0] t, logic [15:0] u);
    send_word(t, u, 0, 0);
  endtask

  task automatic wait_drained();
    hit_ch.valid <= 0;
    while (trig_sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(twct_pkg::reg_idx_e idx, logic [31:0] v);
    psel <= 1;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (idx == twct_pkg::REG_WINDOW) trig_sb.window_ns = v[30:0];
    else trig_sb.threshold = v[5:0];
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    @(posedge clk_i);
  endtask

  // a burst of hits spread over a few units, then maybe a flush
  task automatic random_group(int nunits, int spread);
    int n;
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      clock_ns = clock_ns + $urandom_range(0, spread);
      send_word(clock_ns, 16'($urandom_range(0, nunits)), 0, $urandom_range(0, 4) == 0);
    end
    if ($urandom_range(0, 5) == 0) send_word(63'($urandom), 16'($urandom), 1, 0);
  endtask

  initial begin : stimulus
    trig_sb = new();
    clock_ns = 63'd100;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: empty flush, limits, repeats, reset thresholds
    send_word(63'h7fff_ffff_ffff_ffff, 16'hffff, 1, 0);
    send_hit(63'd0, 16'd0);
    send_hit(63'd0, 16'd1);
    send_hit(63'd1740000000000000001, 16'd2);
    send_hit(63'h7fff_ffff_ffff_ffff, 16'hffff);
    send_hit(63'd10, 16'd1);
    send_hit(63'd20, 16'd2);
    send_hit(63'd5, 16'd3);
    send_hit(63'd30, 16'hffff);
    send_hit(63'd2000, 16'd4);
    send_hit(63'd1740000000000000000, 16'h5555);
    send_hit(63'd1740000000000000000 - 63'd1, 16'haaaa);
    send_word(63'd0, 16'd0, 1, 0);
    wait_drained();

    // threshold 1: every window close fires; window 0
    write_reg(twct_pkg::REG_THRESH, 32'd1);
    write_reg(twct_pkg::REG_WINDOW, 32'd0);
    for (int k = 0; k < 5; k++) send_hit(63'd1000 + 63'(k), 16'(k));
    send_word(63'd0, 16'd0, 1, 0);
    wait_drained();

    // threshold zero, huge window: fill the buffer past full
    write_reg(twct_pkg::REG_THRESH, 32'd0);
    write_reg(twct_pkg::REG_WINDOW, 32'h7fff_ffff);
    for (int k = 0; k < 36; k++) send_word(63'd5000 + 63'(k), 16'(k), 0, 1);
    send_word(63'd0, 16'd0, 1, 0);
    wait_drained();

    // threshold above depth: never fires
    write_reg(twct_pkg::REG_THRESH, 32'd63);
    write_reg(twct_pkg::REG_WINDOW, 32'd10);
    clock_ns = 63'd100000;
    for (int k = 0; k < 3; k++) random_group(40, 30);
    send_word(63'd0, 16'd0, 1, 0);
    wait_drained();

    // random phases over several settings
    clock_ns = 63'd200000;
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(twct_pkg::REG_THRESH, 32'($urandom_range(1, 6)));
      write_reg(twct_pkg::REG_WINDOW, 32'($urandom_range(20, 200)));
      for (int g = 0; g < 2; g++) random_group(8, 40);
      send_word(63'd0, 16'd0, 1, 0);
      wait_drained();
    end
    // exercise high unit bits and wide timestamps
    write_reg(twct_pkg::REG_THRESH, 32'd2);
    clock_ns = 63'd1700000000000000000 + 63'($urandom);
    for (int k = 0; k < 10; k++) begin
      clock_ns = clock_ns + $urandom_range(1, 100);
      send_hit(clock_ns, 16'($urandom));
    end
    send_word(63'd0, 16'd0, 1, 0);
    wait_drained();

    if (trig_sb.errors == 0 && trig_sb.expected_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
